[hw/rtl/bot_pkg.sv]
`timescale 1ns / 1ps

package bot_pkg;

    localparam int MAX_COLUMNS_DEF = 64;
    localparam int MAX_ROWS_DEF    = 64;

    localparam int ROW_BITS_W  = 64;
    localparam int OP_W        = 2;
    localparam int ROW_INDEX_W = 6;
    localparam int COORD_W     = 8;
    localparam int CFG_W       = 7;
    localparam int CFG_INDEX_W = 2;
    localparam int SHIFT_AMT_W = 8;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE_A   = 2'd0,
        OP_WRITE_B   = 2'd1,
        OP_INTERSECT = 2'd2,
        OP_COVERS    = 2'd3
    } op_t;

    localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH_A  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT_A = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH_B  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT_B = 2'd3;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COVER,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic                   left;
        logic [SHIFT_AMT_W-1:0] amount;
    } shift_ctl_t;

endpackage

[hw/rtl/bitmap_overlap_test.sv]
`timescale 1ns / 1ps

// Bitmap overlap tester for two row-word shapes A and B. After reset the block
// clears both row stores, one row per cycle, with busy high; configuration
// writes are taken during that pass. A command beat is taken when start is high
// and busy is low. Row writes leave busy low. A covers query reads the row of A,
// moves to ST_COVER with busy high, then registers its answer on hit with done.
// An intersect query whose offset lies beyond the shape extents answers on the
// next cycle; otherwise it scans one row pair per cycle through the two row RAM
// read ports and the shared shift unit, up to min(height_a, MAX_ROWS) rows, and
// stops at the first overlapping row. done is high for exactly one cycle per
// answer and the receiver cannot stall it.
module bitmap_overlap_test #(
    parameter int MAX_COLUMNS = bot_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = bot_pkg::MAX_ROWS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [bot_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bot_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  logic [bot_pkg::OP_W-1:0]            operation,
    input  logic [bot_pkg::ROW_INDEX_W-1:0]     row_index,
    input  logic [bot_pkg::ROW_BITS_W-1:0]      row_bits,
    input  logic signed [bot_pkg::COORD_W-1:0]  offset_x,
    input  logic signed [bot_pkg::COORD_W-1:0]  offset_y,
    input  logic signed [bot_pkg::COORD_W-1:0]  point_x,
    input  logic signed [bot_pkg::COORD_W-1:0]  point_y,
    output logic                                done,
    output logic                                hit
);

    localparam int AW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNTW = $clog2(MAX_ROWS + 1);
    localparam int JW   = ((CNTW > bot_pkg::COORD_W) ? CNTW : bot_pkg::COORD_W) + 2;
    localparam int PW   = bot_pkg::COORD_W + 2;

    bot_pkg::state_t state_reg, state_next;

    logic [bot_pkg::CFG_W-1:0] width_a_reg, height_a_reg, width_b_reg, height_b_reg;

    logic [AW-1:0]   clr_reg, clr_next;
    logic [CNTW-1:0] i_reg, i_next;
    logic [CNTW-1:0] ha_reg, ha_next;
    logic [CNTW-1:0] hb_reg, hb_next;
    logic signed [bot_pkg::COORD_W-1:0] dx_reg, dx_next;
    logic signed [bot_pkg::COORD_W-1:0] dy_reg, dy_next;
    logic [bot_pkg::SHIFT_AMT_W-1:0]    px_reg, px_next;
    logic cover_ok_reg, cover_ok_next;
    logic pair_valid_reg, pair_valid_next;
    logic done_reg, done_next;
    logic hit_reg, hit_next;

    // RAM ports
    logic                   a_we, b_we;
    logic [AW-1:0]          waddr;
    logic [MAX_COLUMNS-1:0] wdata;
    logic [AW-1:0]          a_raddr, b_raddr;
    logic [MAX_COLUMNS-1:0] a_rdata, b_rdata;

    // shared unit
    logic [MAX_COLUMNS-1:0] su_mask, su_operand;
    bot_pkg::shift_ctl_t    su_ctl;
    logic                   su_any;

    // decode helpers
    logic                   row_ok;
    logic                   out_range;
    logic                   cover_ok;
    logic signed [PW-1:0]   dx_s, dy_s, wa_s, ha_s, wb_s, hb_s;
    logic [CNTW-1:0]        ha_clamp, hb_clamp;
    logic signed [JW-1:0]   j;
    logic                   j_ok;
    logic [31:0]            py_wide;

    bot_ram #(
        .WIDTH (MAX_COLUMNS),
        .DEPTH (MAX_ROWS)
    ) u_ram_a (
        .clk   (clk),
        .we    (a_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    bot_ram #(
        .WIDTH (MAX_COLUMNS),
        .DEPTH (MAX_ROWS)
    ) u_ram_b (
        .clk   (clk),
        .we    (b_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    bot_shift_unit #(
        .WIDTH (MAX_COLUMNS)
    ) u_shift (
        .mask    (su_mask),
        .operand (su_operand),
        .ctl     (su_ctl),
        .any     (su_any)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_a_reg  <= '0;
            height_a_reg <= '0;
            width_b_reg  <= '0;
            height_b_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bot_pkg::CFG_WIDTH_A:  width_a_reg  <= cfg_data;
                bot_pkg::CFG_HEIGHT_A: height_a_reg <= cfg_data;
                bot_pkg::CFG_WIDTH_B:  width_b_reg  <= cfg_data;
                bot_pkg::CFG_HEIGHT_B: height_b_reg <= cfg_data;
            endcase
        end
    end

    // command decode
    always_comb
    begin
        row_ok = (32'({26'd0, row_index}) < 32'(MAX_ROWS));

        dx_s = PW'(offset_x);
        dy_s = PW'(offset_y);
        wa_s = $signed(PW'(width_a_reg));
        ha_s = $signed(PW'(height_a_reg));
        wb_s = $signed(PW'(width_b_reg));
        hb_s = $signed(PW'(height_b_reg));
        out_range = (dx_s > wa_s) || (dy_s > ha_s) || (-dx_s > wb_s) || (-dy_s > hb_s);

        ha_clamp = (32'({25'd0, height_a_reg}) > 32'(MAX_ROWS)) ?
                   CNTW'(MAX_ROWS) : CNTW'(height_a_reg);
        hb_clamp = (32'({25'd0, height_b_reg}) > 32'(MAX_ROWS)) ?
                   CNTW'(MAX_ROWS) : CNTW'(height_b_reg);

        cover_ok = !point_x[bot_pkg::COORD_W-1] && !point_y[bot_pkg::COORD_W-1] &&
                   (point_x[6:0] < width_a_reg) && (point_y[6:0] < height_a_reg) &&
                   (32'({25'd0, point_x[6:0]}) < 32'(MAX_COLUMNS)) &&
                   (32'({25'd0, point_y[6:0]}) < 32'(MAX_ROWS));
        py_wide = {25'd0, point_y[6:0]};

        // row of B paired with row i of A
        j    = $signed(JW'(i_reg)) - JW'(dy_reg);
        j_ok = !j[JW-1] && (unsigned'(j) < JW'(hb_reg));
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bot_pkg::ST_CLEAR;
            clr_reg        <= '0;
            i_reg          <= '0;
            pair_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            i_reg          <= i_next;
            pair_valid_reg <= pair_valid_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ha_reg       <= ha_next;
        hb_reg       <= hb_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        px_reg       <= px_next;
        cover_ok_reg <= cover_ok_next;
        hit_reg      <= hit_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        i_next          = i_reg;
        ha_next         = ha_reg;
        hb_next         = hb_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        px_next         = px_reg;
        cover_ok_next   = cover_ok_reg;
        pair_valid_next = 1'b0;
        done_next       = 1'b0;
        hit_next        = hit_reg;

        a_we    = 1'b0;
        b_we    = 1'b0;
        waddr   = AW'(32'({26'd0, row_index}));
        wdata   = row_bits[MAX_COLUMNS-1:0];
        a_raddr = i_reg[AW-1:0];
        b_raddr = j[AW-1:0];

        su_mask       = a_rdata;
        su_operand    = b_rdata;
        su_ctl.left   = !dx_reg[bot_pkg::COORD_W-1];
        su_ctl.amount = dx_reg[bot_pkg::COORD_W-1] ? (~dx_reg + 1'b1) : dx_reg;

        unique case (state_reg)
            bot_pkg::ST_CLEAR:
            begin
                a_we  = 1'b1;
                b_we  = 1'b1;
                waddr = clr_reg;
                wdata = '0;
                if (clr_reg == AW'(MAX_ROWS - 1))
                begin
                    state_next = bot_pkg::ST_IDLE;
                end
                else
                begin
                    clr_next = AW'(clr_reg + 1'b1);
                end
            end

            bot_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    unique case (bot_pkg::op_t'(operation))
                        bot_pkg::OP_WRITE_A:
                        begin
                            a_we = row_ok;
                        end
                        bot_pkg::OP_WRITE_B:
                        begin
                            b_we = row_ok;
                        end
                        bot_pkg::OP_INTERSECT:
                        begin
                            if (out_range)
                            begin
                                done_next = 1'b1;
                                hit_next  = 1'b0;
                            end
                            else
                            begin
                                state_next = bot_pkg::ST_SCAN;
                                i_next     = '0;
                                ha_next    = ha_clamp;
                                hb_next    = hb_clamp;
                                dx_next    = offset_x;
                                dy_next    = offset_y;
                            end
                        end
                        bot_pkg::OP_COVERS:
                        begin
                            a_raddr       = AW'(py_wide);
                            cover_ok_next = cover_ok;
                            px_next       = {1'b0, point_x[6:0]};
                            state_next    = bot_pkg::ST_COVER;
                        end
                    endcase
                end
            end

            bot_pkg::ST_COVER:
            begin
                // bit x of the row: shift right by x, keep bit 0
                su_mask       = MAX_COLUMNS'(1);
                su_operand    = a_rdata;
                su_ctl.left   = 1'b0;
                su_ctl.amount = px_reg;
                done_next     = 1'b1;
                hit_next      = cover_ok_reg && su_any;
                state_next    = bot_pkg::ST_IDLE;
            end

            bot_pkg::ST_SCAN:
            begin
                // issue the read for row i; the pair read last cycle is checked now
                if (i_reg != ha_reg)
                begin
                    pair_valid_next = j_ok;
                end
                if (pair_valid_reg && su_any)
                begin
                    done_next       = 1'b1;
                    hit_next        = 1'b1;
                    pair_valid_next = 1'b0;
                    state_next      = bot_pkg::ST_IDLE;
                end
                else if (i_reg == ha_reg)
                begin
                    done_next  = 1'b1;
                    hit_next   = 1'b0;
                    state_next = bot_pkg::ST_IDLE;
                end
                else
                begin
                    i_next = CNTW'(i_reg + 1'b1);
                end
            end
        endcase
    end

    assign busy = (state_reg != bot_pkg::ST_IDLE);
    assign done = done_reg;
    assign hit  = hit_reg;

    // a row write never produces an answer
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operation == bot_pkg::OP_WRITE_A ||
                            operation == bot_pkg::OP_WRITE_B)) |=> !done)
        else $error("answer after row write");

    // after a covers beat busy is high, then done comes with busy low
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation == bot_pkg::OP_COVERS) |=> busy ##1 (done && !busy))
        else $error("covers answer missing");

    // an answer only follows work in the cycle before
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("answer without a query");

    // a scan never runs past the clamped height of A
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bot_pkg::ST_SCAN) |-> (i_reg <= ha_reg))
        else $error("scan row counter overrun");

endmodule

[hw/rtl/bot_ram.sv]
`timescale 1ns / 1ps

module bot_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/bot_shift_unit.sv]
`timescale 1ns / 1ps

// Shared shift / AND / any-bit unit: |(mask & (operand shifted)).
module bot_shift_unit #(
    parameter int WIDTH = 64
) (
    input  logic [WIDTH-1:0]      mask,
    input  logic [WIDTH-1:0]      operand,
    input  bot_pkg::shift_ctl_t   ctl,
    output logic                  any
);

    logic [WIDTH-1:0] shifted;

    always_comb
    begin
        // shift amounts at or beyond WIDTH give zero, dropping every bit
        if (ctl.left)
        begin
            shifted = operand << ctl.amount;
        end
        else
        begin
            shifted = operand >> ctl.amount;
        end
    end

    assign any = |(mask & shifted);

endmodule
